// ===== hdl/ppmr_pkg.sv =====
// Shared types and constants for the PPM receiver.
package ppmr_pkg;

  localparam logic [31:0] SyncGapUs = 32'd2050;
  localparam logic [31:0] GlitchUs  = 32'd450;
  localparam logic [15:0] AuxTop    = 16'd100;

  typedef enum logic [2:0] {
    REG_STICK_MIN    = 3'd0,
    REG_STICK_MAX    = 3'd1,
    REG_ARM_TOL      = 3'd2,
    REG_LINK_TIMEOUT = 3'd3,
    REG_ARM_HOLD     = 3'd4,
    REG_MAX_TILT     = 3'd5,
    REG_THR_LIMIT    = 3'd6,
    REG_MAX_YAW      = 3'd7
  } reg_idx_e;

  // Request from sequencer to the serial divider.
  typedef struct packed {
    logic        start;
    logic [29:0] dividend;
    logic [11:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [29:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/ppmr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ppmr_div
  import ppmr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [29:0] quo_q, quo_d;
  logic [12:0] rem_q, rem_d;
  logic [11:0] dsr_q, dsr_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [12:0] trial;

  // Load a new request, or shift one dividend bit into the partial remainder and try a subtract.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[11:0], quo_q[29]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = 5'd29;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[28:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[28:0], 1'b0};
      end
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/ppm_receiver_with_arming.sv =====
// Top level of the PPM receiver with stick-gesture arming.
// A pulse edge is accepted in the idle state and applied in the edge update
// state. A poll maps six channels one after another through a shared restoring
// divider that retires one quotient bit per cycle. Each channel forms the
// dividend, starts the divider, runs the divide and captures the quotient; the
// arming step follows the last channel, and with an empty stick span the divider
// is skipped. A failsafe poll goes straight to the output state.
// One item is worked on at a time; the result sits in an output register while
// the next item may be accepted, and a poll only starts mapping once the
// previous result has left.
module ppm_receiver_with_arming
  import ppmr_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] time_us_i,
  input  logic [31:0] time_ms_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        link_error_o,
  output logic signed [15:0] roll_cmd_o,
  output logic signed [15:0] pitch_cmd_o,
  output logic [15:0] throttle_cmd_o,
  output logic signed [15:0] yaw_rate_cmd_o,
  output logic [6:0]  aux_one_o,
  output logic [6:0]  aux_two_o,
  output logic        armed_flag_o
);

  localparam int IdxW = $clog2(CHANNELS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EDGE, ST_POLL, ST_DIV, ST_WAIT, ST_ARM, ST_OUT
  } state_e;

  // Configuration registers.
  logic [11:0] stick_min_q, stick_max_q, max_tilt_q;
  logic [9:0]  arm_tol_q;
  logic [15:0] link_to_q, arm_hold_q, thr_lim_q;
  logic [13:0] max_yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_min_q <= 12'd1000;
      stick_max_q <= 12'd2000;
      arm_tol_q   <= 10'd50;
      link_to_q   <= 16'd500;
      arm_hold_q  <= 16'd1000;
      max_tilt_q  <= 12'd480;
      thr_lim_q   <= 16'd16000;
      max_yaw_q   <= 14'd2880;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_STICK_MIN:    stick_min_q <= cfg_data_i[11:0];
        REG_STICK_MAX:    stick_max_q <= cfg_data_i[11:0];
        REG_ARM_TOL:      arm_tol_q   <= cfg_data_i[9:0];
        REG_LINK_TIMEOUT: link_to_q   <= cfg_data_i;
        REG_ARM_HOLD:     arm_hold_q  <= cfg_data_i;
        REG_MAX_TILT:     max_tilt_q  <= cfg_data_i[11:0];
        REG_THR_LIMIT:    thr_lim_q   <= cfg_data_i;
        REG_MAX_YAW:      max_yaw_q   <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  // Decoder and arming state.
  state_e      state_q;
  logic [11:0] width_q [CHANNELS];
  logic [31:0] pstart_q, lframe_q, gstart_q, tus_q, tms_q;
  logic [IdxW-1:0] chan_q;
  logic        lfail_q, armed_q;
  logic [1:0]  phase_q;
  logic [2:0]  map_q;
  logic [15:0] res_q [6];
  logic        ov_q, lerr_q, aflag_q;
  logic [29:0] prod_q;
  logic        neg_q;

  div_req_t dreq;
  div_rsp_t drsp;
  ppmr_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [31:0] dus, dms;
  logic [11:0] span, wraw, wcl, off;
  logic        span_ok;
  logic [15:0] mtop;
  logic        symm;
  logic [12:0] ad2, ad3lo, ad3hi;
  logic        low_w, arm_g, dis_g;

  assign dus = tus_q - pstart_q;
  assign dms = tms_q - lframe_q;
  assign span = stick_max_q - stick_min_q;
  assign span_ok = stick_max_q > stick_min_q;

  // Select the channel and scale for the current mapping step.
  always_comb begin
    wraw = 12'd0;
    if (32'(map_q) < CHANNELS) wraw = width_q[IdxW'(map_q)];
    wcl = (wraw < stick_min_q) ? stick_min_q :
          (wraw > stick_max_q) ? stick_max_q : wraw;
    off = wcl - stick_min_q;
    case (map_q)
      3'd0, 3'd1: begin mtop = {4'd0, max_tilt_q}; symm = 1'b1; end
      3'd2:       begin mtop = thr_lim_q;          symm = 1'b0; end
      3'd3:       begin mtop = {2'd0, max_yaw_q};  symm = 1'b1; end
      default:    begin mtop = AuxTop;             symm = 1'b0; end
    endcase
  end

  // Gesture detection on raw widths.
  function automatic logic [12:0] adist(logic [11:0] a, logic [11:0] b);
    return (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction
  assign ad2   = adist(width_q[2], stick_min_q);
  assign ad3lo = adist(width_q[3], stick_min_q);
  assign ad3hi = adist(width_q[3], stick_max_q);
  assign low_w = ad2 < {3'd0, arm_tol_q};
  assign arm_g = low_w && ad3hi < {3'd0, arm_tol_q};
  assign dis_g = low_w && ad3lo < {3'd0, arm_tol_q};

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    dreq.start    = (state_q == ST_DIV);
    dreq.dividend = prod_q;
    dreq.divisor  = span;
  end

  // Sequencer: hold state, step mapping, drive the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      for (int i = 0; i < CHANNELS; i++) width_q[i] <= '0;
      pstart_q <= '0; lframe_q <= '0; gstart_q <= '0;
      chan_q   <= '0; lfail_q <= 1'b0; armed_q <= 1'b0; phase_q <= '0;
      ov_q     <= 1'b0; map_q <= '0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_acc) begin
          tus_q <= time_us_i;
          tms_q <= time_ms_i;
          state_q <= opcode_i ? ST_POLL : ST_EDGE;
        end
        ST_EDGE: begin
          lfail_q  <= dms >= {16'd0, link_to_q};
          pstart_q <= tus_q;
          state_q  <= ST_IDLE;
          if (dus > SyncGapUs) begin
            chan_q <= '0;
          end else if (dus >= GlitchUs) begin
            width_q[chan_q] <= dus[11:0];
            if (32'(chan_q) >= CHANNELS - 1) begin
              lframe_q <= tms_q;
              chan_q   <= '0;
            end else begin
              chan_q <= chan_q + 1'b1;
            end
          end
        end
        ST_POLL: begin
          // Hold until the previous result has left the output register.
          if (!ov_q || !out_stall_i) begin
            map_q <= '0;
            if (lfail_q || dms > {16'd0, link_to_q}) begin
              lerr_q <= 1'b1; aflag_q <= 1'b0;
              for (int i = 0; i < 6; i++) res_q[i] <= '0;
              state_q <= ST_OUT;
            end else begin
              lerr_q <= 1'b0;
              state_q <= ST_WAIT;
              prod_q <= '0;
            end
          end
        end
        ST_WAIT: begin
          // Registered dividend (one multiply); an empty span sets the result.
          if (!span_ok) begin
            res_q[map_q] <= symm ? 16'(-mtop) : 16'd0;
            if (map_q == 3'd5) state_q <= ST_ARM;
            map_q <= map_q + 3'd1;
          end else begin
            if (symm) begin
              if ({off, 1'b0} >= {1'b0, span}) begin
                neg_q  <= 1'b0;
                prod_q <= 30'(({1'b0, off, 1'b0} - {1'b0, span}) * {12'd0, mtop[13:0]});
              end else begin
                neg_q  <= 1'b1;
                prod_q <= 30'(({1'b0, span} - {1'b0, off, 1'b0}) * {12'd0, mtop[13:0]});
              end
            end else begin
              neg_q  <= 1'b0;
              prod_q <= 30'({18'd0, off} * {14'd0, mtop});
            end
            state_q <= ST_DIV;
          end
        end
        ST_DIV: state_q <= ST_OUT;
        ST_OUT: begin
          if (lerr_q) begin
            if (!ov_q || !out_stall_i) begin
              ov_q <= 1'b1; state_q <= ST_IDLE;
            end
          end else if (map_q == 3'd6) begin
            if (!ov_q || !out_stall_i) begin
              ov_q <= 1'b1; state_q <= ST_IDLE;
            end
          end else if (drsp.done) begin
            res_q[map_q] <= neg_q ? 16'(-drsp.quotient[15:0]) : drsp.quotient[15:0];
            map_q   <= map_q + 3'd1;
            state_q <= (map_q == 3'd5) ? ST_ARM : ST_WAIT;
          end
        end
        ST_ARM: begin
          if (arm_g && !armed_q) begin
            if (phase_q != 2'd1) begin
              gstart_q <= tms_q; phase_q <= 2'd1;
            end else if (tms_q - gstart_q >= {16'd0, arm_hold_q}) begin
              armed_q <= 1'b1;
            end
            aflag_q <= (phase_q == 2'd1 && tms_q - gstart_q >= {16'd0, arm_hold_q})
                       ? 1'b1 : armed_q;
          end else if (dis_g && armed_q) begin
            if (phase_q != 2'd2) begin
              gstart_q <= tms_q; phase_q <= 2'd2;
            end else if (tms_q - gstart_q >= {16'd0, arm_hold_q}) begin
              armed_q <= 1'b0;
            end
            aflag_q <= (phase_q == 2'd2 && tms_q - gstart_q >= {16'd0, arm_hold_q})
                       ? 1'b0 : armed_q;
          end else begin
            phase_q <= 2'd0;
            aflag_q <= armed_q;
          end
          map_q   <= 3'd6;
          state_q <= ST_OUT;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = ov_q;
  assign link_error_o   = lerr_q;
  assign roll_cmd_o     = res_q[0];
  assign pitch_cmd_o    = res_q[1];
  assign throttle_cmd_o = res_q[2];
  assign yaw_rate_cmd_o = res_q[3];
  assign aux_one_o      = res_q[4][6:0];
  assign aux_two_o      = res_q[5][6:0];
  assign armed_flag_o   = aflag_q;

endmodule

// ===== test/ppmr_monitor.sv =====
// Transfer monitor for the PPM receiver: predicts poll commands and compares them.
module ppmr_monitor
  import ppmr_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        opcode_i,
  input  logic [31:0] time_us_i,
  input  logic [31:0] time_ms_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        link_error_i,
  input  logic [15:0] roll_cmd_i,
  input  logic [15:0] pitch_cmd_i,
  input  logic [15:0] throttle_cmd_i,
  input  logic [15:0] yaw_rate_cmd_i,
  input  logic [6:0]  aux_one_i,
  input  logic [6:0]  aux_two_i,
  input  logic        armed_flag_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic        link_error;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] throttle;
    logic [15:0] yaw;
    logic [6:0]  aux_one;
    logic [6:0]  aux_two;
    logic        armed;
  } cmd_t;

  cmd_t cmd_q[$];

  // Register copies
  logic [11:0] smin, smax, max_tilt;
  logic [9:0]  arm_tol;
  logic [15:0] link_to, hold_ms, thr_limit;
  logic [13:0] max_yaw;

  // Decoder and arming state
  logic [11:0] width_q[8];
  logic [31:0] edge_start_us, last_frame, gesture_start;
  logic [2:0]  chan_idx;
  logic        link_bad, armed;
  logic [1:0]  phase;

  assign pending_o = cmd_q.size();

  function automatic logic [11:0] clamp_w(input logic [11:0] w);
    if (w < smin) return smin;
    if (w > smax) return smax;
    return w;
  endfunction

  function automatic logic [15:0] scale_up(input logic [11:0] w, input logic [15:0] top);
    longint unsigned off, span;
    if (smax <= smin) return 16'd0;
    span = longint'(smax - smin);
    off  = longint'(clamp_w(w) - smin);
    return 16'((off * top) / span);
  endfunction

  function automatic logic [15:0] scale_sym(input logic [11:0] w, input logic [13:0] m);
    longint unsigned off, span, a, b, q;
    if (smax <= smin) return 16'd0 - 16'(m);
    span = longint'(smax - smin);
    off  = longint'(clamp_w(w) - smin);
    a = off * 2 * m;
    b = longint'(m) * span;
    if (a >= b) begin
      q = (a - b) / span;
      return q[15:0];
    end
    q = (b - a) / span;
    return 16'd0 - q[15:0];
  endfunction

  function automatic logic near_end(input logic [11:0] w, input logic [11:0] target);
    logic [11:0] d;
    d = (w >= target) ? w - target : target - w;
    return d < arm_tol;
  endfunction

  // Advance the arm machine on a healthy poll
  task automatic step_arming(input logic [31:0] now);
    logic low, arm_g, disarm_g;
    low      = near_end(width_q[2], smin);
    arm_g    = low && near_end(width_q[3], smax);
    disarm_g = low && near_end(width_q[3], smin);
    if (arm_g && !armed) begin
      if (phase != 2'd1) begin
        gesture_start = now;
        phase = 2'd1;
      end else if (now - gesture_start >= 32'(hold_ms)) begin
        armed = 1'b1;
      end
    end else if (disarm_g && armed) begin
      if (phase != 2'd2) begin
        gesture_start = now;
        phase = 2'd2;
      end else if (now - gesture_start >= 32'(hold_ms)) begin
        armed = 1'b0;
      end
    end else begin
      phase = 2'd0;
    end
  endtask

  // Apply one accepted item, queue the command a poll produces
  task automatic apply_item(input logic op, input logic [31:0] tus, input logic [31:0] tms);
    logic [31:0] d;
    cmd_t c;
    if (!op) begin
      link_bad = (tms - last_frame >= 32'(link_to));
      d = tus - edge_start_us;
      edge_start_us = tus;
      if (d > SyncGapUs) begin
        chan_idx = 3'd0;
      end else if (d >= GlitchUs) begin
        if (chan_idx >= 3'(CHANNELS - 1)) begin
          width_q[CHANNELS - 1] = d[11:0];
          last_frame = tms;
          chan_idx = 3'd0;
        end else begin
          width_q[chan_idx] = d[11:0];
          chan_idx++;
        end
      end
      return;
    end
    c = '{link_error: 1'b1, default: '0};
    if (!(link_bad || (tms - last_frame > 32'(link_to)))) begin
      c.link_error = 1'b0;
      c.roll       = scale_sym(width_q[0], 14'(max_tilt));
      c.pitch      = scale_sym(width_q[1], 14'(max_tilt));
      c.throttle   = scale_up(width_q[2], thr_limit);
      c.yaw        = scale_sym(width_q[3], max_yaw);
      c.aux_one    = 7'(scale_up(width_q[4], AuxTop));
      c.aux_two    = 7'(scale_up(width_q[5], AuxTop));
      step_arming(tms);
      c.armed      = armed;
    end
    cmd_q.push_back(c);
  endtask

  task automatic cmp(input string name, input logic [15:0] exp_v, input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Watch the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t e;
    if (!rst_ni) begin
      cmd_q.delete();
      fail_count_o = 0;
      smin = 12'd1000; smax = 12'd2000; arm_tol = 10'd50; link_to = 16'd500;
      hold_ms = 16'd1000; max_tilt = 12'd480; thr_limit = 16'd16000; max_yaw = 14'd2880;
      foreach (width_q[i]) width_q[i] = '0;
      edge_start_us = '0; last_frame = '0; gesture_start = '0;
      chan_idx = '0; link_bad = 1'b0; armed = 1'b0; phase = 2'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_STICK_MIN:    smin      = cfg_data_i[11:0];
          REG_STICK_MAX:    smax      = cfg_data_i[11:0];
          REG_ARM_TOL:      arm_tol   = cfg_data_i[9:0];
          REG_LINK_TIMEOUT: link_to   = cfg_data_i;
          REG_ARM_HOLD:     hold_ms   = cfg_data_i;
          REG_MAX_TILT:     max_tilt  = cfg_data_i[11:0];
          REG_THR_LIMIT:    thr_limit = cfg_data_i;
          REG_MAX_YAW:      max_yaw   = cfg_data_i[13:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (cmd_q.size() == 0) begin
          $error("command transfer with no command expected");
          fail_count_o++;
        end else begin
          e = cmd_q.pop_front();
          cmp("link_error", 16'(e.link_error), 16'(link_error_i));
          cmp("roll_cmd", e.roll, roll_cmd_i);
          cmp("pitch_cmd", e.pitch, pitch_cmd_i);
          cmp("throttle_cmd", e.throttle, throttle_cmd_i);
          cmp("yaw_rate_cmd", e.yaw, yaw_rate_cmd_i);
          cmp("aux_one", 16'(e.aux_one), 16'(aux_one_i));
          cmp("aux_two", 16'(e.aux_two), 16'(aux_two_i));
          cmp("armed_flag", 16'(e.armed), 16'(armed_flag_i));
        end
      end
      if (in_valid_i && !in_stall_i) apply_item(opcode_i, time_us_i, time_ms_i);
    end
  end

endmodule

// ===== test/testbench.sv =====
// Stimulus and verdict for the PPM receiver with arming.
module testbench;
  import ppmr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        opcode_i = 1'b0;
  logic [31:0] time_us_i = '0;
  logic [31:0] time_ms_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o, cfg_ready_o, out_valid_o, link_error_o, armed_flag_o;
  logic signed [15:0] roll_cmd_o, pitch_cmd_o, yaw_rate_cmd_o;
  logic [15:0] throttle_cmd_o;
  logic [6:0]  aux_one_o, aux_two_o;
  int          fail_count, pending;

  int unsigned send_idle_pct, stall_pct;
  logic [31:0] now_us, now_ms;
  logic [15:0] cfg_val[8];

  always #10 clk_i = ~clk_i;

  ppm_receiver_with_arming u_top (.*);

  ppmr_monitor u_mon (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .time_us_i,
    .time_ms_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .link_error_i(link_error_o),
    .roll_cmd_i(roll_cmd_o), .pitch_cmd_i(pitch_cmd_o), .throttle_cmd_i(throttle_cmd_o),
    .yaw_rate_cmd_i(yaw_rate_cmd_o), .aux_one_i(aux_one_o), .aux_two_i(aux_two_o),
    .armed_flag_i(armed_flag_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Random receiver stall
  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  // Hard stop
  initial begin
    #80_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Send one item; returns at the edge where it transfers
  task automatic send(input logic op, input logic [31:0] tus, input logic [31:0] tms);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    time_us_i  <= tus;
    time_ms_i  <= tms;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic edge_after(input int unsigned gap_us);
    now_us += gap_us;
    now_ms += $urandom_range(0, 2);
    send(1'b0, now_us, now_ms);
  endtask

  task automatic poll_after(input int unsigned gap_ms);
    now_ms += gap_ms;
    send(1'b1, now_us, now_ms);
  endtask

  // Hold until every command is back and the block has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i  <= cfg_val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pulse width aimed at stick ends, or anywhere in the legal window
  function automatic int unsigned pick_width();
    int w;
    case ($urandom_range(0, 3))
      0: w = int'(cfg_val[REG_STICK_MIN]) + $urandom_range(0, 120) - 60;
      1: w = int'(cfg_val[REG_STICK_MAX]) + $urandom_range(0, 120) - 60;
      default: w = $urandom_range(450, 2050);
    endcase
    if (w < 1) w = 1;
    return w;
  endfunction

  // Sync gap, channel widths with an occasional glitch or early cut
  task automatic frame();
    edge_after($urandom_range(2100, 9000));
    for (int ch = 0; ch < 8; ch++) begin
      if ($urandom_range(0, 99) < 4) edge_after($urandom_range(1, 449));
      if ($urandom_range(0, 99) < 2) break;
      edge_after(pick_width());
    end
  endtask

  task automatic load_setting(input int p);
    case (p)
      0: cfg_val = '{16'd1000, 16'd2000, 16'd50, 16'd500, 16'd20, 16'd480, 16'd16000,
                     16'd2880};
      1: cfg_val = '{16'd0, 16'd4095, 16'd1023, 16'd65535, 16'd0, 16'd4095, 16'd65535,
                     16'd16383};
      2: cfg_val = '{16'd1500, 16'd1500, 16'd0, 16'd1, 16'd65535, 16'd0, 16'd0, 16'd0};
      3: cfg_val = '{16'd1900, 16'd1100, 16'd100, 16'd2000, 16'd5, 16'd1000, 16'd40000,
                     16'd8000};
      default: begin
        cfg_val[REG_STICK_MIN]    = 16'($urandom_range(800, 1300));
        cfg_val[REG_STICK_MAX]    = 16'($urandom_range(1600, 2200));
        cfg_val[REG_ARM_TOL]      = 16'($urandom_range(0, 1023));
        cfg_val[REG_LINK_TIMEOUT] = 16'($urandom_range(1, 65535));
        cfg_val[REG_ARM_HOLD]     = 16'($urandom_range(0, 40));
        cfg_val[REG_MAX_TILT]     = 16'($urandom_range(0, 4095));
        cfg_val[REG_THR_LIMIT]    = 16'($urandom_range(0, 65535));
        cfg_val[REG_MAX_YAW]      = 16'($urandom_range(0, 16383));
      end
    endcase
  endtask

  initial begin
    int sent;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_setting(0);
    write_regs();

    // Directed: reset poll, a wrapping frame at stick ends, arming, stale link, extremes
    now_us = 32'hFFFF_FC00;
    now_ms = 32'hFFFF_FFF0;
    send(1'b1, 32'd0, 32'd0);
    edge_after(3000);
    edge_after(1000);
    edge_after(2000);
    edge_after(100);
    edge_after(1000);
    edge_after(2000);
    edge_after(1500);
    edge_after(2050);
    edge_after(450);
    edge_after(1800);
    poll_after(1);
    poll_after(30);
    poll_after(600);
    send(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(1'b0, 32'd0, 32'd0);
    send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(1'b1, 32'd0, 32'd0);
    drain();

    // Random phases under each setting and idle pattern
    for (int p = 0; p < 5; p++) begin
      load_setting(p);
      write_regs();
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        3: begin send_idle_pct = 26; stall_pct = 26; end
        default: begin
          send_idle_pct = $urandom_range(0, 47);
          stall_pct = $urandom_range(0, 47);
        end
      endcase
      sent = 0;
      while (sent < 160) begin
        if ($urandom_range(0, 99) < 8) begin
          send(1'($urandom), $urandom, $urandom);
          sent++;
        end else begin
          frame();
          sent += 9;
          repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 99) < 6) poll_after($urandom_range(0, 70000));
            else poll_after($urandom_range(0, 15));
            sent++;
          end
        end
        if (p == 1 && sent >= 80 && sent < 90) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
